[src/spg_pkg.sv]
// Shared types, codes and default constants for the stepper pulse generator.
// Used by spg_div and stepper_pulse_generator_with_jog_core; no dependencies.
`default_nettype none

package spg_pkg;

    // Fixed field widths
    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int REQ_W       = 3;
    localparam int RPM_W       = 16;
    localparam int RPM_MAG_W   = 15;
    localparam int SCALE_W     = 8;
    localparam int MAXRPM_W    = 15;
    localparam int STATUS_W    = 3;
    localparam int DIVISOR_W   = RPM_MAG_W + SCALE_W;
    localparam int DIV_CNT_W   = $clog2(CFG_W);

    // Parameter defaults
    localparam int DEF_DEBOUNCE_LEN  = 8;
    localparam int DEF_INTERVAL_BITS = 18;

    // Register reset values
    localparam logic [CFG_W-1:0]    DEF_JOG_INTERVAL  = 18'd44;
    localparam logic [CFG_W-1:0]    DEF_ZERO_INTERVAL = 18'd200000;
    localparam logic [CFG_W-1:0]    DEF_SPEED_NUM     = 18'd200000;
    localparam logic [SCALE_W-1:0]  DEF_RPM_SCALE     = 8'd9;
    localparam logic [MAXRPM_W-1:0] DEF_MAX_RPM       = 15'd1000;
    localparam logic [CFG_W-1:0]    RESET_HALF_PERIOD = 18'd5000;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 3'd0,
        REQ_STOP      = 3'd1,
        REQ_RUN       = 3'd2,
        REQ_SET_SPEED = 3'd3,
        REQ_FORWARD   = 3'd4,
        REQ_REVERSE   = 3'd5,
        REQ_UNKNOWN   = 3'd6
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NONE      = 3'd0,
        STAT_STOPPED   = 3'd1,
        STAT_SPEED_OK  = 3'd2,
        STAT_BAD_RPM   = 3'd3,
        STAT_BAD_CMD   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JOG_INTERVAL  = 3'd0,
        CFG_ZERO_INTERVAL = 3'd1,
        CFG_SPEED_NUM     = 3'd2,
        CFG_RPM_SCALE     = 3'd3,
        CFG_MAX_RPM       = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_LOAD,
        SEQ_DIV
    } t_seq_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[src/spg_div.sv]
// Restoring divider, one quotient bit per cycle, for the speed interval.
// Depends on spg_pkg.
`default_nettype none

module spg_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire spg_pkg::t_div_ctrl             i_ctrl,
    input  wire logic [spg_pkg::CFG_W-1:0]      i_dividend,
    input  wire logic [spg_pkg::DIVISOR_W-1:0]  i_divisor,
    output spg_pkg::t_div_stat                  o_stat,
    output logic [spg_pkg::CFG_W-1:0]           o_quotient
);
    import spg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [CFG_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_den;

    logic [DIVISOR_W:0]   w_trial;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_fits;

    // One shift-and-subtract step
    always_comb begin
        w_trial = {r_rem, r_quo[CFG_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_fits  = (w_trial >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(CFG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[CFG_W-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

[src/stepper_pulse_generator_with_jog_core.sv]
// Stepper step-pulse generator with switch jog: top level, sequencer, state.
// Depends on spg_pkg and spg_div.
//
// channel  direction  handshake                  payload
// in       request    i_in_valid / o_in_stall    i_req_type i_rpm i_up_switch i_down_switch
// out      request    o_out_valid / i_out_stall  o_step_out o_dir_out o_enable_n_out o_status
// cfg      write      i_cfg_we                   i_cfg_index i_cfg_data
//
// Ticks and all commands but a valid nonzero set speed finish in the accept cycle.
// A valid nonzero set speed holds the input while the sequencer steps through
// MUL (the rpm times scale product), LOAD (divider start) and DIV (the
// restoring divider's quotient bits) and loads the result; a zero divisor loads in LOAD.
// Reset is synchronous and loads every state register at once.
// A request is taken in SEQ_IDLE while the output register is empty or being drained.
`default_nettype none

module stepper_pulse_generator_with_jog_core #(
    parameter int DEBOUNCE_LEN  = spg_pkg::DEF_DEBOUNCE_LEN,
    parameter int INTERVAL_BITS = spg_pkg::DEF_INTERVAL_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [spg_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic signed [spg_pkg::RPM_W-1:0]   i_rpm,
    input  wire logic                               i_up_switch,
    input  wire logic                               i_down_switch,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_step_out,
    output logic                                    o_dir_out,
    output logic                                    o_enable_n_out,
    output logic [spg_pkg::STATUS_W-1:0]            o_status,
    input  wire logic                               i_cfg_we,
    input  wire logic [spg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [spg_pkg::CFG_W-1:0]          i_cfg_data
);
    import spg_pkg::*;

    localparam int SAT_W = (INTERVAL_BITS > CFG_W) ? INTERVAL_BITS : CFG_W;
    localparam logic [SAT_W-1:0] IVAL_MAX_W = SAT_W'({INTERVAL_BITS{1'b1}});
    localparam logic [INTERVAL_BITS-1:0] IVAL_MAX = {INTERVAL_BITS{1'b1}};

    // Clamp an 18-bit interval into the half-period width
    function automatic logic [INTERVAL_BITS-1:0] sat_ival(input logic [CFG_W-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > IVAL_MAX_W) begin
            return IVAL_MAX;
        end
        return w[INTERVAL_BITS-1:0];
    endfunction

    // Configuration registers
    logic [CFG_W-1:0]    r_jog_interval;
    logic [CFG_W-1:0]    r_zero_interval;
    logic [CFG_W-1:0]    r_speed_num;
    logic [SCALE_W-1:0]  r_rpm_scale;
    logic [MAXRPM_W-1:0] r_max_rpm;

    // Motor state
    t_seq_state                r_state, n_state;
    logic                      r_run, n_run;
    logic                      r_jog, n_jog;
    logic                      r_dir, n_dir;
    logic [INTERVAL_BITS-1:0]  r_half, n_half;
    logic [INTERVAL_BITS-1:0]  r_elapsed, n_elapsed;
    logic                      r_phase, n_phase;
    logic                      r_step_pin, n_step_pin;
    logic                      r_dir_pin, n_dir_pin;
    logic                      r_enable_pin, n_enable_pin;
    logic [DEBOUNCE_LEN-1:0]   r_up_hist, n_up_hist;
    logic [DEBOUNCE_LEN-1:0]   r_down_hist, n_down_hist;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_step;
    logic                r_out_dir;
    logic                r_out_enable;
    t_status             r_out_status;

    // Speed operands
    logic [RPM_MAG_W-1:0] r_rpm_mag;
    logic [DIVISOR_W-1:0] r_divisor;

    logic                 w_accept;
    logic                 w_load;
    t_status              w_status;
    t_req                 w_req;
    logic [RPM_MAG_W-1:0] w_mag;
    t_div_ctrl            div_ctrl;
    t_div_stat            div_stat;
    logic [CFG_W-1:0]     div_quotient;

    spg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (r_speed_num),
        .i_divisor  (r_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

    assign o_in_stall = (r_state != SEQ_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_req      = t_req'(i_req_type);
    assign w_mag      = i_rpm[RPM_MAG_W-1:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jog_interval  <= DEF_JOG_INTERVAL;
            r_zero_interval <= DEF_ZERO_INTERVAL;
            r_speed_num     <= DEF_SPEED_NUM;
            r_rpm_scale     <= DEF_RPM_SCALE;
            r_max_rpm       <= DEF_MAX_RPM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_JOG_INTERVAL:  r_jog_interval  <= i_cfg_data;
                CFG_ZERO_INTERVAL: r_zero_interval <= i_cfg_data;
                CFG_SPEED_NUM:     r_speed_num     <= i_cfg_data;
                CFG_RPM_SCALE:     r_rpm_scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_MAX_RPM:       r_max_rpm       <= i_cfg_data[MAXRPM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and request handling
    always_comb begin
        n_state      = r_state;
        n_run        = r_run;
        n_jog        = r_jog;
        n_dir        = r_dir;
        n_half       = r_half;
        n_elapsed    = r_elapsed;
        n_phase      = r_phase;
        n_step_pin   = r_step_pin;
        n_dir_pin    = r_dir_pin;
        n_enable_pin = r_enable_pin;
        n_up_hist    = r_up_hist;
        n_down_hist  = r_down_hist;
        n_out_valid  = r_out_valid && i_out_stall;
        w_load       = 1'b0;
        w_status     = STAT_NONE;
        div_ctrl     = '0;

        unique case (r_state)
            SEQ_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    unique case (w_req)
                        REQ_TICK: begin
                            // debounce and jog only while not running
                            if (!r_run) begin
                                n_up_hist   = {r_up_hist[DEBOUNCE_LEN-2:0], i_up_switch};
                                n_down_hist = {r_down_hist[DEBOUNCE_LEN-2:0], i_down_switch};
                                if (n_up_hist == '0) begin
                                    n_jog        = 1'b1;
                                    n_dir        = 1'b1;
                                    n_dir_pin    = 1'b1;
                                    n_half       = sat_ival(r_jog_interval);
                                    n_enable_pin = 1'b0;
                                end else if (n_down_hist == '0) begin
                                    n_jog        = 1'b1;
                                    n_dir        = 1'b0;
                                    n_dir_pin    = 1'b0;
                                    n_half       = sat_ival(r_jog_interval);
                                    n_enable_pin = 1'b0;
                                end else begin
                                    n_jog        = 1'b0;
                                    n_enable_pin = 1'b1;
                                end
                            end
                            // saturating tick count, then step check
                            if (r_elapsed != IVAL_MAX) begin
                                n_elapsed = r_elapsed + 1'b1;
                            end
                            if ((r_run || n_jog) && (n_elapsed >= n_half)) begin
                                n_elapsed  = '0;
                                n_phase    = !r_phase;
                                n_step_pin = !r_phase;
                            end
                        end
                        REQ_STOP: begin
                            n_run        = 1'b0;
                            n_step_pin   = 1'b0;
                            n_enable_pin = 1'b1;
                            w_status     = STAT_STOPPED;
                        end
                        REQ_RUN: begin
                            n_run        = 1'b1;
                            n_enable_pin = 1'b0;
                        end
                        REQ_FORWARD: begin
                            n_run     = 1'b1;
                            n_dir     = 1'b1;
                            n_dir_pin = 1'b1;
                        end
                        REQ_REVERSE: begin
                            n_run     = 1'b1;
                            n_dir     = 1'b0;
                            n_dir_pin = 1'b0;
                        end
                        REQ_SET_SPEED: begin
                            if (i_rpm[RPM_W-1] || (w_mag > r_max_rpm)) begin
                                w_status = STAT_BAD_RPM;
                            end else if (w_mag == '0) begin
                                n_half   = sat_ival(r_zero_interval);
                                w_status = STAT_SPEED_OK;
                            end else begin
                                // result comes from the divider later
                                w_load  = 1'b0;
                                n_state = SEQ_MUL;
                            end
                        end
                        default: begin
                            w_status = STAT_BAD_CMD;
                        end
                    endcase
                end
            end
            SEQ_MUL: begin
                n_state = SEQ_LOAD;
            end
            SEQ_LOAD: begin
                // zero divisor only when the scale is zero
                if (r_divisor == '0) begin
                    n_half   = IVAL_MAX;
                    w_load   = 1'b1;
                    w_status = STAT_SPEED_OK;
                    n_state  = SEQ_IDLE;
                end else begin
                    div_ctrl.start = 1'b1;
                    n_state        = SEQ_DIV;
                end
            end
            SEQ_DIV: begin
                if (div_stat.done) begin
                    n_half   = sat_ival(div_quotient);
                    w_load   = 1'b1;
                    w_status = STAT_SPEED_OK;
                    n_state  = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SEQ_IDLE;
            r_run        <= 1'b0;
            r_jog        <= 1'b0;
            r_dir        <= 1'b1;
            r_half       <= sat_ival(RESET_HALF_PERIOD);
            r_elapsed    <= '0;
            r_phase      <= 1'b0;
            r_step_pin   <= 1'b0;
            r_dir_pin    <= 1'b0;
            r_enable_pin <= 1'b0;
            r_up_hist    <= '1;
            r_down_hist  <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_jog        <= n_jog;
            r_dir        <= n_dir;
            r_half       <= n_half;
            r_elapsed    <= n_elapsed;
            r_phase      <= n_phase;
            r_step_pin   <= n_step_pin;
            r_dir_pin    <= n_dir_pin;
            r_enable_pin <= n_enable_pin;
            r_up_hist    <= n_up_hist;
            r_down_hist  <= n_down_hist;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers: result fields and speed operands
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_step   <= n_step_pin;
            r_out_dir    <= n_dir_pin;
            r_out_enable <= n_enable_pin;
            r_out_status <= w_status;
        end
        if (w_accept) begin
            r_rpm_mag <= w_mag;
        end
        if (r_state == SEQ_MUL) begin
            r_divisor <= DIVISOR_W'(r_rpm_mag) * DIVISOR_W'(r_rpm_scale);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_out     = r_out_step;
    assign o_dir_out      = r_out_dir;
    assign o_enable_n_out = r_out_enable;
    assign o_status       = r_out_status;

    // Checks
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == SEQ_DIV))
        else $error("divider finished outside the divide state");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_out_valid || (r_state != SEQ_IDLE)))
        else $error("accepted request produced no result and no work");

    a_stop_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_req == REQ_STOP)) |=> (!o_step_out && o_enable_n_out))
        else $error("stop did not drop step pin and disable driver");

    a_div_idle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> o_in_stall)
        else $error("request taken while divider busy");

endmodule

`default_nettype wire

[verif/stepper_pulse_generator_with_jog_core_tb.sv]
// Self-checking testbench for stepper_pulse_generator_with_jog_core.
// Depends on spg_pkg and the core RTL. A queue-fed driver, a clocked monitor
// and a behavioral pin predictor check every result against the request order.

module stepper_pulse_generator_with_jog_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spg_pkg::*;

    localparam int HIST_W = DEF_DEBOUNCE_LEN;
    localparam logic [CFG_W-1:0] IVAL_MAX = '1;
    localparam logic [REQ_W-1:0] REQ_SPARE_SEL = 3'd7;       // undefined selector
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;   // past the register list
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = 3'd7;
    localparam int IDLE_PCT = 9;
    localparam int SETTLE_CYCLES = 40;   // margin for a nonzero set speed to pass the divider

    typedef struct packed {
        logic [REQ_W-1:0]        kind;
        logic signed [RPM_W-1:0] rpm;
        logic                    up_n;
        logic                    dn_n;
    } request_t;

    typedef struct packed {
        logic    step;
        logic    dir;
        logic    enable_n;
        t_status status;
    } pins_t;

    // DUT ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [REQ_W-1:0]        i_req_type = '0;
    logic signed [RPM_W-1:0] i_rpm = '0;
    logic                    i_up_switch = 1'b1;
    logic                    i_down_switch = 1'b1;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_step_out;
    logic                    o_dir_out;
    logic                    o_enable_n_out;
    logic [STATUS_W-1:0]     o_status;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    stepper_pulse_generator_with_jog_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_rpm          (i_rpm),
        .i_up_switch    (i_up_switch),
        .i_down_switch  (i_down_switch),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_step_out     (o_step_out),
        .o_dir_out      (o_dir_out),
        .o_enable_n_out (o_enable_n_out),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of registers and drive state
    logic [CFG_W-1:0]    cfg_jog, cfg_zero, cfg_num;
    logic [SCALE_W-1:0]  cfg_scale;
    logic [MAXRPM_W-1:0] cfg_maxrpm;
    logic                running, jogging, phase, step_lvl, dir_lvl, en_n;
    logic [CFG_W-1:0]    half_per, elapsed;
    logic [HIST_W-1:0]   up_hist, dn_hist;

    request_t cmd_backlog[$];
    pins_t    pin_forecast[$];

    bit calm = 1'b0;       // no idling on either side while set
    bit in_fire = 1'b0;    // request taken at the last rising edge
    bit sw_up = 1'b1;
    bit sw_dn = 1'b1;
    int errors = 0;
    int n_requests = 0, n_results = 0, n_toggles = 0, n_jog_ticks = 0;
    int n_speed_ok = 0, n_speed_bad = 0, n_cfg_writes = 0;

    // Predict the pins and status after one request
    function automatic pins_t advance_drive(request_t rq);
        pins_t                r;
        logic [RPM_MAG_W-1:0] mag;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIVISOR_W-1:0] quot;
        r.status = STAT_NONE;
        case (rq.kind)
            REQ_TICK: begin
                // debounce only while not commanded to run
                if (!running) begin
                    up_hist = {up_hist[HIST_W-2:0], rq.up_n};
                    dn_hist = {dn_hist[HIST_W-2:0], rq.dn_n};
                    if (up_hist == '0) begin
                        jogging = 1'b1;
                        dir_lvl = 1'b1;
                        half_per = cfg_jog;
                        en_n = 1'b0;
                    end else if (dn_hist == '0) begin
                        jogging = 1'b1;
                        dir_lvl = 1'b0;
                        half_per = cfg_jog;
                        en_n = 1'b0;
                    end else begin
                        jogging = 1'b0;
                        en_n = 1'b1;
                    end
                    if (jogging) n_jog_ticks++;
                end
                if (elapsed != IVAL_MAX) elapsed++;
                if ((running || jogging) && elapsed >= half_per) begin
                    elapsed = '0;
                    phase = !phase;
                    step_lvl = phase;
                    n_toggles++;
                end
            end
            REQ_STOP: begin
                running = 1'b0;
                step_lvl = 1'b0;
                en_n = 1'b1;
                r.status = STAT_STOPPED;
            end
            REQ_RUN: begin
                running = 1'b1;
                en_n = 1'b0;
            end
            REQ_SET_SPEED: begin
                mag = rq.rpm[RPM_MAG_W-1:0];
                if (rq.rpm[RPM_W-1] || mag > cfg_maxrpm) begin
                    r.status = STAT_BAD_RPM;
                    n_speed_bad++;
                end else begin
                    if (mag == '0) begin
                        half_per = cfg_zero;
                    end else begin
                        divisor = mag * cfg_scale;
                        quot = (divisor == '0) ? DIVISOR_W'(IVAL_MAX) : cfg_num / divisor;
                        half_per = quot[CFG_W-1:0];
                    end
                    r.status = STAT_SPEED_OK;
                    n_speed_ok++;
                end
            end
            REQ_FORWARD: begin
                running = 1'b1;
                dir_lvl = 1'b1;
            end
            REQ_REVERSE: begin
                running = 1'b1;
                dir_lvl = 1'b0;
            end
            default: r.status = STAT_BAD_CMD;
        endcase
        r.step = step_lvl;
        r.dir = dir_lvl;
        r.enable_n = en_n;
        return r;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Monitor: check results first, then predict for a newly taken request
    always @(posedge i_clk) begin
        pins_t    want;
        pins_t    seen;
        request_t rq;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.step = o_step_out;
            seen.dir = o_dir_out;
            seen.enable_n = o_enable_n_out;
            seen.status = t_status'(o_status);
            n_results++;
            if (pin_forecast.size() == 0) begin
                flag_error($sformatf("result with no request pending: step %b dir %b en_n %b st %0d",
                    seen.step, seen.dir, seen.enable_n, o_status));
            end else begin
                want = pin_forecast.pop_front();
                if (seen !== want)
                    flag_error($sformatf(
                        "result %0d: step %b/%b dir %b/%b en_n %b/%b status %0d/%0d (exp/act)",
                        n_results, want.step, seen.step, want.dir, seen.dir,
                        want.enable_n, seen.enable_n, want.status, o_status));
            end
        end
        if (in_fire) begin
            rq.kind = i_req_type;
            rq.rpm = i_rpm;
            rq.up_n = i_up_switch;
            rq.dn_n = i_down_switch;
            pin_forecast.push_back(advance_drive(rq));
            n_requests++;
        end
    end

    // Driver: new request or idle on the falling edge
    always @(negedge i_clk) begin
        request_t rq;
        if (!i_in_valid || in_fire) begin
            if (cmd_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                rq = cmd_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= rq.kind;
                i_rpm <= rq.rpm;
                i_up_switch <= rq.up_n;
                i_down_switch <= rq.dn_n;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic push_req(logic [REQ_W-1:0] kind, logic [RPM_W-1:0] rpm = '0,
                            logic up_n = 1'b1, logic dn_n = 1'b1);
        request_t rq;
        rq.kind = kind;
        rq.rpm = rpm;
        rq.up_n = up_n;
        rq.dn_n = dn_n;
        cmd_backlog.push_back(rq);
    endtask

    // Register write through the config port, mirrored into the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg_writes++;
        case (idx)
            CFG_JOG_INTERVAL:  cfg_jog = val;
            CFG_ZERO_INTERVAL: cfg_zero = val;
            CFG_SPEED_NUM:     cfg_num = val;
            CFG_RPM_SCALE:     cfg_scale = val[SCALE_W-1:0];
            CFG_MAX_RPM:       cfg_maxrpm = val[MAXRPM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [CFG_W-1:0] jog, logic [CFG_W-1:0] zero,
                            logic [CFG_W-1:0] num, logic [CFG_W-1:0] scale,
                            logic [CFG_W-1:0] maxr);
        write_reg(CFG_JOG_INTERVAL, jog);
        write_reg(CFG_ZERO_INTERVAL, zero);
        write_reg(CFG_SPEED_NUM, num);
        write_reg(CFG_RPM_SCALE, scale);
        write_reg(CFG_MAX_RPM, maxr);
    endtask

    // Wait for the backlog and all results to drain, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_in_valid || pin_forecast.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Speed values: mostly in range, plus zero, limits, negatives and overruns
    function automatic logic [RPM_W-1:0] pick_rpm();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RPM_W'($urandom_range(32768, 65535));
            2: return (cfg_maxrpm == '1) ? RPM_W'(cfg_maxrpm)
                                         : RPM_W'($urandom_range(cfg_maxrpm + 1, 32767));
            3: return RPM_W'($urandom);
            4: return RPM_W'(cfg_maxrpm);
            default: return RPM_W'($urandom_range(1, cfg_maxrpm));
        endcase
    endfunction

    // Random traffic: ticks with held switch levels and short glitches,
    // mixed with commands
    task automatic queue_random(int n);
        int roll;
        logic [REQ_W-1:0] kind;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                if ($urandom_range(0, 15) == 0) sw_up = !sw_up;
                if ($urandom_range(0, 15) == 0) sw_dn = !sw_dn;
                push_req(REQ_TICK, RPM_W'($urandom),
                         sw_up ^ ($urandom_range(0, 29) == 0),
                         sw_dn ^ ($urandom_range(0, 29) == 0));
            end else if (roll < 80) begin
                push_req(REQ_SET_SPEED, pick_rpm(), 1'($urandom), 1'($urandom));
            end else begin
                if (roll < 88)      kind = REQ_STOP;
                else if (roll < 91) kind = REQ_RUN;
                else if (roll < 94) kind = REQ_FORWARD;
                else if (roll < 97) kind = REQ_REVERSE;
                else if (roll < 99) kind = REQ_UNKNOWN;
                else                kind = REQ_SPARE_SEL;
                push_req(kind, RPM_W'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Stimulus and phase sequencing
    initial begin
        cfg_jog = DEF_JOG_INTERVAL;
        cfg_zero = DEF_ZERO_INTERVAL;
        cfg_num = DEF_SPEED_NUM;
        cfg_scale = DEF_RPM_SCALE;
        cfg_maxrpm = DEF_MAX_RPM;
        running = 1'b0;
        jogging = 1'b0;
        phase = 1'b0;
        step_lvl = 1'b0;
        dir_lvl = 1'b0;
        en_n = 1'b0;
        half_per = RESET_HALF_PERIOD;
        elapsed = '0;
        up_hist = '1;
        dn_hist = '1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values: every request kind and rpm limits
        push_req(REQ_TICK);
        push_req(REQ_UNKNOWN);
        push_req(REQ_SPARE_SEL);
        push_req(REQ_SET_SPEED, 16'sd0);
        push_req(REQ_SET_SPEED, -16'sd1);
        push_req(REQ_SET_SPEED, 16'h8000);
        push_req(REQ_SET_SPEED, 16'sd32767);
        push_req(REQ_SET_SPEED, 16'sd1001);
        push_req(REQ_SET_SPEED, 16'sd1000);
        push_req(REQ_FORWARD);
        repeat (23) push_req(REQ_TICK);
        push_req(REQ_SET_SPEED, 16'sd1);
        push_req(REQ_REVERSE);
        push_req(REQ_RUN);
        push_req(REQ_STOP);
        push_req(REQ_TICK);
        drain();

        // Zero jog interval, tiny quotients: a step on every tick
        set_regs('0, 18'd1, 18'd1, 18'd255, 18'd32767);
        write_reg(CFG_IDX_SPARE, '1);
        write_reg(CFG_IDX_LAST, 18'h15555);
        repeat (10) push_req(REQ_TICK, '0, 1'b0, 1'b1);     // up jog after debounce
        repeat (8) push_req(REQ_TICK, '0, 1'b1, 1'b0);      // down jog
        push_req(REQ_TICK, '0, 1'b1, 1'b1);                 // release ends jog
        push_req(REQ_SET_SPEED, 16'sd32767);                // quotient of zero
        push_req(REQ_FORWARD);
        repeat (2) push_req(REQ_TICK);
        push_req(REQ_SET_SPEED, 16'sd0);
        push_req(REQ_REVERSE);
        push_req(REQ_TICK);
        queue_random(200);
        drain();

        // Largest jog, zero-speed and numerator values, unit scale, narrowest rpm window
        set_regs('1, '1, '1, 18'd1, 18'd1);
        queue_random(150);
        drain();

        // Scale and max rpm written as zero through the upper data bits
        set_regs(18'd2, 18'd7, 18'd3000, 18'h3FF00, 18'h38000);
        queue_random(100);
        drain();

        // Mid-range settings with no idling on either side
        calm = 1'b1;
        set_regs(18'd3, 18'd50, 18'd600, 18'd2, 18'd40);
        queue_random(400);
        drain();
        calm = 1'b0;

        // Typical settings
        set_regs(18'd5, 18'd300, 18'd2000, 18'd9, 18'd1000);
        queue_random(450);
        drain();

        if (pin_forecast.size() != 0)
            flag_error($sformatf("%0d results never arrived", pin_forecast.size()));
        $display("Run covered %0d requests and %0d results: %0d step toggles, %0d jog ticks,",
                 n_requests, n_results, n_toggles, n_jog_ticks);
        $display("%0d speeds loaded, %0d rejected, %0d register writes; %0d mismatches.",
                 n_speed_ok, n_speed_bad, n_cfg_writes, errors);
        if (errors == 0) begin
            $display("** stepper_pulse_generator_with_jog_core: PASSED **");
        end else begin
            $display("** stepper_pulse_generator_with_jog_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d requests and %0d results pending",
                 cmd_backlog.size(), pin_forecast.size());
        $display("** stepper_pulse_generator_with_jog_core: FAILED **");
        $finish;
    end

endmodule
